FILE: rtl/core/cvt_pkg.sv
package cvt_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int OPER_W     = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_REPLACE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_FIND    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } status_t;

    typedef logic [DATA_WIDTH-1:0] value_t;

    // Command broadcast to every cell during the execute cycle.
    typedef struct packed {
        logic   valid;
        op_t    op;
        value_t key;
        value_t new_value;
        logic   full;
    } cvt_cmd_t;

    // Position of one cell relative to the fill count.
    typedef struct packed {
        logic occupied;
        logic has_next;
        logic is_tail;
    } cvt_pos_t;

    function automatic value_t to_value(input logic signed [OPER_W-1:0] x);
        logic signed [OPER_W+DATA_WIDTH-1:0] wide;
        wide = (OPER_W + DATA_WIDTH)'(x);
        return wide[DATA_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/core/compacting_value_table.sv
// Compacting value table: a packed table of signed values with a fill count.
// A command is taken at a rising edge where start is high and busy is low;
// busy is never raised, so a new transaction may follow in every cycle.
// The operation is op with operands key and new_value: append, replace all
// matches, delete the first match, or find the first match.
// The command is registered on acceptance and executed in the next cycle by a
// row of cells, one per entry. Each cell compares its entry with the key and
// passes a "match seen below" flag up the row; on delete every cell at or
// above the first match and below the last entry takes its upper neighbor's
// value in that same cycle. The result (found, index, count, status) is
// registered at the end of that cycle and shows with done high for one cycle;
// every transaction gets exactly one. Throughput is one transaction per cycle,
// set by the update of the cell row; each transaction sees the updates of all earlier ones.
// The receiver cannot stall; results must be taken in the cycle they show.
// Reset clears the fill count and the pending command; entries stay unwritten
// until an append fills them.
module compacting_value_table
    import cvt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                op,
    input  logic signed [OPER_W-1:0]  key,
    input  logic signed [OPER_W-1:0]  new_value,
    output logic                      done,
    output logic                      found,
    output logic [INDEX_W-1:0]        index,
    output logic [COUNT_W-1:0]        count,
    output logic [1:0]                status
);

    logic             exec_reg;
    op_t              op_reg;
    value_t           key_reg;
    value_t           nv_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    logic             done_reg;
    logic             found_reg;
    logic [IDX_W-1:0] index_reg;
    logic [CNT_W-1:0] count_reg;
    status_t          status_reg;

    cvt_cmd_t         cmd;
    logic [CAPACITY-1:0] hit;
    logic [CAPACITY:0]   seen;
    value_t           cell_value [CAPACITY];
    logic             any_hit;
    logic [IDX_W-1:0] first_idx;
    logic             full;
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (fill_reg >= CNT_W'(CAPACITY));

    assign cmd.valid     = exec_reg;
    assign cmd.op        = op_reg;
    assign cmd.key       = key_reg;
    assign cmd.new_value = nv_reg;
    assign cmd.full      = full;

    assign seen[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            cvt_pos_t pos;
            value_t   nb_value;

            assign pos.occupied = (CNT_W'(g) < fill_reg);
            assign pos.has_next = (CNT_W'(g + 1) < fill_reg);
            assign pos.is_tail  = (CNT_W'(g) == fill_reg);

            if (g == CAPACITY - 1)
            begin : g_last
                assign nb_value = cell_value[g];
            end
            else
            begin : g_inner
                assign nb_value = cell_value[g + 1];
            end

            cvt_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos        (pos),
                .seen_in    (seen[g]),
                .next_value (nb_value),
                .hit        (hit[g]),
                .seen_out   (seen[g + 1]),
                .value      (cell_value[g])
            );
        end
    endgenerate

    assign any_hit = seen[CAPACITY];

    always_comb
    begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (exec_reg)
        begin
            if (op_reg == OP_APPEND && !full)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            else if (op_reg == OP_DELETE && any_hit)
            begin
                fill_next = fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg <= 1'b0;
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            exec_reg <= accept;
            fill_reg <= fill_next;
            done_reg <= exec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(op);
            key_reg <= to_value(key);
            nv_reg  <= to_value(new_value);
        end
        if (exec_reg)
        begin
            count_reg <= fill_next;
            if (op_reg == OP_APPEND)
            begin
                found_reg  <= 1'b0;
                index_reg  <= full ? '0 : fill_reg[IDX_W-1:0];
                status_reg <= full ? ST_FULL : ST_OK;
            end
            else
            begin
                found_reg  <= any_hit;
                index_reg  <= any_hit ? first_idx : '0;
                status_reg <= any_hit ? ST_OK : ST_NOMATCH;
            end
        end
    end

    assign done   = done_reg;
    assign found  = found_reg;
    assign index  = INDEX_W'(index_reg);
    assign count  = COUNT_W'(count_reg);
    assign status = status_reg;

endmodule

FILE: rtl/core/cvt_cell.sv
module cvt_cell
    import cvt_pkg::*;
(
    input  logic     clk,
    input  cvt_cmd_t cmd,
    input  cvt_pos_t pos,
    input  logic     seen_in,
    input  value_t   next_value,
    output logic     hit,
    output logic     seen_out,
    output value_t   value
);

    value_t value_reg;
    value_t value_next;

    assign value    = value_reg;
    assign hit      = pos.occupied && (value_reg == cmd.key);
    assign seen_out = seen_in || hit;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.valid)
        begin
            case (cmd.op)
                OP_APPEND:
                begin
                    if (pos.is_tail && !cmd.full)
                    begin
                        value_next = cmd.new_value;
                    end
                end
                OP_REPLACE:
                begin
                    if (hit)
                    begin
                        value_next = cmd.new_value;
                    end
                end
                OP_DELETE:
                begin
                    if (seen_out && pos.has_next)
                    begin
                        value_next = next_value;
                    end
                end
                default:
                begin
                    value_next = value_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: rtl/core/cvt_checker.sv
module cvt_checker
    import cvt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     done,
    input  logic                     found,
    input  logic [INDEX_W-1:0]       index,
    input  logic [COUNT_W-1:0]       count,
    input  logic [1:0]               status
);

    a_result_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done
    ) else $error("Accepted transaction produced no result.");

    a_no_spurious_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2)
    ) else $error("Result without an accepted transaction.");

    a_full_means_capacity: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (count == COUNT_W'(CAPACITY) && !found)
    ) else $error("Full status while the table has room.");

    a_nomatch_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && status == ST_NOMATCH) |-> (!found && index == '0)
    ) else $error("No-match result carries a hit or an index.");

    a_status_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_FULL || status == ST_NOMATCH)
    ) else $error("Result status is a reserved code.");

endmodule

bind compacting_value_table cvt_checker u_cvt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .found  (found),
    .index  (index),
    .count  (count),
    .status (status)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cvt_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef struct {
        logic                found;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  count;
        status_t             status;
    } table_result_t;

    class table_scoreboard;
        value_t        slots [CAPACITY];
        int            fill = 0;
        table_result_t expected_q [$];
        int            errors = 0;

        function void note_command(input op_t o,
                                   input logic signed [OPER_W-1:0] key_in,
                                   input logic signed [OPER_W-1:0] value_in);
            value_t        kv;
            value_t        nv;
            int            hit;
            table_result_t r;
            kv = key_in;
            nv = value_in;
            hit = -1;
            r.found = 1'b0;
            r.index = '0;
            r.status = ST_OK;
            if (o == OP_APPEND)
            begin
                if (fill >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slots[fill] = nv;
                    r.index = INDEX_W'(fill);
                    fill++;
                end
            end
            else
            begin
                for (int i = fill - 1; i >= 0; i--)
                begin
                    if (slots[i] == kv)
                    begin
                        hit = i;
                    end
                end
                if (hit < 0)
                begin
                    r.status = ST_NOMATCH;
                end
                else
                begin
                    r.found = 1'b1;
                    r.index = INDEX_W'(hit);
                    if (o == OP_REPLACE)
                    begin
                        for (int i = hit; i < fill; i++)
                        begin
                            if (slots[i] == kv)
                            begin
                                slots[i] = nv;
                            end
                        end
                    end
                    else if (o == OP_DELETE)
                    begin
                        for (int i = hit; i < fill - 1; i++)
                        begin
                            slots[i] = slots[i + 1];
                        end
                        fill--;
                    end
                end
            end
            r.count = COUNT_W'(fill);
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic f, input logic [INDEX_W-1:0] idx,
                                   input logic [COUNT_W-1:0] cnt, input logic [1:0] st);
            table_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: found=%0d index=%0d count=%0d status=%0d",
                       f, idx, cnt, st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (f !== e.found)
            begin
                $error("found: expected %0d, actual %0d", e.found, f);
                errors++;
            end
            if (idx !== e.index)
            begin
                $error("index: expected %0d, actual %0d", e.index, idx);
                errors++;
            end
            if (cnt !== e.count)
            begin
                $error("count: expected %0d, actual %0d", e.count, cnt);
                errors++;
            end
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                op = OP_APPEND;
    logic signed [OPER_W-1:0]  key = '0;
    logic signed [OPER_W-1:0]  new_value = '0;
    logic                      done;
    logic                      found;
    logic [INDEX_W-1:0]        index;
    logic [COUNT_W-1:0]        count;
    logic [1:0]                status;

    table_scoreboard sb = new();
    int              quiet_cycles = 0;
    bit              grow = 1'b1;

    compacting_value_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .key       (key),
        .new_value (new_value),
        .done      (done),
        .found     (found),
        .index     (index),
        .count     (count),
        .status    (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(found, index, count, status);
            end
            if ((start && !busy) || done)
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    function automatic logic [OPER_W-1:0] pool_value();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h5A5A_5A5A;
        endcase
    endfunction

    task automatic issue(input op_t o, input logic [OPER_W-1:0] k,
                         input logic [OPER_W-1:0] v);
        @(negedge clk);
        start <= 1'b1;
        op <= o;
        key <= k;
        new_value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(o, k, v);
    endtask

    task automatic pause_sender();
        @(negedge clk);
        start <= 1'b0;
        op <= 2'($urandom);
        key <= $urandom;
        new_value <= $urandom;
    endtask

    task automatic run_random(input int items, input int idle_pct);
        op_t               o;
        logic [OPER_W-1:0] k;
        logic [OPER_W-1:0] v;
        int                r;
        for (int n = 0; n < items; n++)
        begin
            while ($urandom_range(99) < idle_pct) pause_sender();
            if (grow && sb.fill == CAPACITY && $urandom_range(3) == 0)
            begin
                grow = 1'b0;
            end
            else if (!grow && sb.fill == 0 && $urandom_range(3) == 0)
            begin
                grow = 1'b1;
            end
            r = $urandom_range(99);
            if (grow)
            begin
                o = (r < 55) ? OP_APPEND : (r < 70) ? OP_REPLACE :
                    (r < 80) ? OP_DELETE : OP_FIND;
            end
            else
            begin
                o = (r < 10) ? OP_APPEND : (r < 25) ? OP_REPLACE :
                    (r < 75) ? OP_DELETE : OP_FIND;
            end
            if (sb.fill != 0 && $urandom_range(3) != 0)
            begin
                k = sb.slots[$urandom_range(sb.fill - 1)];
            end
            else if ($urandom_range(1) == 1)
            begin
                k = pool_value();
            end
            else
            begin
                k = $urandom;
            end
            v = ($urandom_range(1) == 1) ? pool_value() : $urandom;
            issue(o, k, v);
        end
    endtask

    initial
    begin
        logic [OPER_W-1:0] v;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(OP_FIND, 32'h0000_0000, 32'h0000_0000);
        issue(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(OP_REPLACE, 32'h8000_0000, 32'h0000_0001);
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (i)
                0: v = 32'h8000_0000;
                1, 5, 9: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                3: v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            issue(OP_APPEND, $urandom, v);
        end
        issue(OP_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
        issue(OP_REPLACE, 32'h7FFF_FFFF, 32'h1234_5678);
        issue(OP_FIND, 32'h1234_5678, 32'hFFFF_FFFF);
        issue(OP_DELETE, 32'h8000_0000, 32'h0000_0000);
        issue(OP_DELETE, sb.slots[sb.fill - 1], 32'h0000_0000);
        issue(OP_FIND, 32'h7FFF_FFFF, 32'h0000_0000);

        run_random(500, 28);
        run_random(250, 86);
        run_random(500, 0);

        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
